// ===== rtl/core/wpm_pkg.sv =====
`timescale 1ns / 1ps

package wpm_pkg;

    // Largest pattern the store can hold
    localparam int MAX_PATTERN_DEF = 64;

    // Pattern length counter width, wide enough to hold the full depth
    localparam int LEN_W = 7;

    localparam int SYM_W = 8;

    // Wildcard bytes
    localparam logic [SYM_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [SYM_W-1:0] ANY_BYTE  = 8'h3F;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_START  = 2'd2,
        CMD_TEXT   = 2'd3
    } t_cmd;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic             step;   // a transaction is accepted this cycle
        t_cmd             cmd;
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] len;    // current pattern length
        logic [LEN_W-1:0] n_len;  // pattern length after this transaction
        logic             full;   // append would be dropped
    } t_ctrl;

    // Handed from one cell to its right-hand neighbor
    typedef struct packed {
        logic left_new;     // new row bit of the left cell
        logic up_old;       // old row bit of the left cell (diagonal)
        logic star_prefix;  // left cell and all before it are '*'
    } t_link;

endpackage

// ===== rtl/core/wpm_in_if.sv =====
`timescale 1ns / 1ps

interface wpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] symbol;

    modport source (output valid, output command, output symbol, input ready);
    modport sink   (input valid, input command, input symbol, output ready);
endinterface

// ===== rtl/core/wpm_out_if.sv =====
`timescale 1ns / 1ps

interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== rtl/core/wpm_cell.sv =====
`timescale 1ns / 1ps

module wpm_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wpm_pkg::t_ctrl i_ctrl,
    input  wpm_pkg::t_link i_link,
    output wpm_pkg::t_link o_link,
    output logic          o_hit
);
    import wpm_pkg::*;

    logic [SYM_W-1:0] r_byte, n_byte;
    logic             r_star, n_star;
    logic             r_row, n_row;
    logic             active;
    logic             wr;
    logic             cell_val;

    // Position inside the stored pattern, and the append slot
    assign active = LEN_W'(IDX) < i_ctrl.len;
    assign wr     = (i_ctrl.cmd == CMD_APPEND) && !i_ctrl.full
                    && (i_ctrl.len == LEN_W'(IDX));

    // One table entry: '*' takes left (ripple) or above, '?' and equal bytes take diagonal
    always_comb begin
        if (!active) begin
            cell_val = 1'b0;
        end else if (r_byte == STAR_BYTE) begin
            cell_val = i_link.left_new | r_row;
        end else if ((r_byte == ANY_BYTE) || (r_byte == i_ctrl.symbol)) begin
            cell_val = i_link.up_old;
        end else begin
            cell_val = 1'b0;
        end
    end

    // Next state per command
    always_comb begin
        n_byte = wr ? i_ctrl.symbol : r_byte;
        if (i_ctrl.cmd == CMD_CLEAR) begin
            n_star = 1'b0;
        end else if (wr) begin
            n_star = i_link.star_prefix && (i_ctrl.symbol == STAR_BYTE);
        end else begin
            n_star = r_star;
        end
        unique case (i_ctrl.cmd)
            CMD_CLEAR:  n_row = 1'b0;
            CMD_APPEND: n_row = n_star;
            CMD_START:  n_row = n_star;
            CMD_TEXT:   n_row = cell_val;
            default:    n_row = 1'b0;
        endcase
    end

    // Pattern byte needs no reset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_byte <= n_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_star <= 1'b0;
            r_row  <= 1'b0;
        end else if (i_ctrl.step) begin
            r_star <= n_star;
            r_row  <= n_row;
        end
    end

    assign o_link.left_new    = cell_val;
    assign o_link.up_old      = r_row;
    assign o_link.star_prefix = r_star;

    // This cell is the last pattern position after the transaction
    assign o_hit = n_row && (i_ctrl.n_len == LEN_W'(IDX + 1));

endmodule

// ===== rtl/core/wildcard_pattern_matcher.sv =====
`timescale 1ns / 1ps

// Streaming whole-string wildcard matcher ('?' any byte, '*' any run).
// Input channel i_in carries command and symbol: clear pattern, append a
// pattern byte, start a new text, or one text byte. Output channel o_out
// returns one transaction per input: matched (text so far matches the whole
// pattern) and pattern_overflow (an append was dropped, store full).
// Each pattern position is one cell in a chain; a cell keeps its pattern
// byte, its star-prefix bit and its bit of the current match row, and passes
// its row bits to the right-hand neighbor, where '*' cells ripple along.
// The result is registered and offered in the cycle after acceptance.
// Throughput: 1 transaction per cycle unless stalled; the combinational ripple
// through the cell chain (up to MAX_PATTERN cells) sets the cycle time.
// Input ready is high while the output register is empty or being taken; a
// stalled receiver holds the result and stops input acceptance.
// Reset: empty pattern, empty text, no result pending; input is ready as
// soon as reset is released.
module wildcard_pattern_matcher #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wpm_in_if.sink    i_in,
    wpm_out_if.source o_out
);
    import wpm_pkg::*;

    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_empty, n_empty;
    logic                 r_valid;
    logic                 r_matched, n_matched;
    logic                 r_overflow, n_overflow;
    logic                 step;
    logic                 full;
    t_cmd                 cmd;
    t_ctrl                ctrl;
    t_link                head;
    t_link                link_out [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hits;

    assign i_in.ready = !r_valid || o_out.ready;
    assign step       = i_in.valid && i_in.ready;
    assign cmd        = t_cmd'(i_in.command);
    assign full       = r_len >= LEN_W'(MAX_PATTERN);

    // Length, empty-text flag, overflow and match updates
    always_comb begin
        unique case (cmd)
            CMD_CLEAR:  n_len = '0;
            CMD_APPEND: n_len = full ? r_len : r_len + LEN_W'(1);
            CMD_START:  n_len = r_len;
            CMD_TEXT:   n_len = r_len;
            default:    n_len = r_len;
        endcase
        n_empty    = (cmd != CMD_TEXT);
        n_overflow = (cmd == CMD_APPEND) && full;
        n_matched  = (n_len == '0) ? n_empty : |hits;
    end

    assign ctrl.step   = step;
    assign ctrl.cmd    = cmd;
    assign ctrl.symbol = i_in.symbol;
    assign ctrl.len    = r_len;
    assign ctrl.n_len  = n_len;
    assign ctrl.full   = full;

    // Left edge of the chain: empty pattern prefix column
    assign head.left_new    = 1'b0;
    assign head.up_old      = r_empty;
    assign head.star_prefix = 1'b1;

    // Cell chain
    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            wpm_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (ctrl),
                .i_link  ((g == 0) ? head : link_out[(g == 0) ? 0 : g - 1]),
                .o_link  (link_out[g]),
                .o_hit   (hits[g])
            );
        end
    endgenerate

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_empty <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            if (step) begin
                r_len   <= n_len;
                r_empty <= n_empty;
            end
            if (step) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_matched  <= n_matched;
            r_overflow <= n_overflow;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.matched          = r_matched;
    assign o_out.pattern_overflow = r_overflow;

endmodule

// ===== tb/wildcard_pattern_matcher_test.sv =====
`timescale 1ns / 1ps

module wildcard_pattern_matcher_test;
    import wpm_pkg::*;

    localparam int PATTERN_DEPTH = MAX_PATTERN_DEF;
    localparam int RANDOM_ITEMS  = 950;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    // Golden match state plus the queue of verdicts still owed by the block
    class match_scoreboard;
        logic [SYM_W-1:0]       pattern_mem [PATTERN_DEPTH];
        int                     pattern_len;
        logic [PATTERN_DEPTH-1:0] star_row;
        logic [PATTERN_DEPTH-1:0] match_row;
        logic                   text_empty;
        t_verdict               owed_verdicts [$];
        int                     mismatches;

        function new();
            pattern_len = 0;
            star_row    = '0;
            match_row   = '0;
            text_empty  = 1'b1;
            mismatches  = 0;
        endfunction

        function void restart_text();
            match_row  = star_row;
            text_empty = 1'b1;
        endfunction

        // One row of the DP table; '*' takes its left neighbor's new bit
        function void consume_byte(logic [SYM_W-1:0] c);
            logic [PATTERN_DEPTH-1:0] next_row;
            logic left_new;
            logic diag_old;
            logic up_old;
            logic entry;
            next_row = '0;
            left_new = 1'b0;
            diag_old = text_empty;
            for (int j = 0; j < pattern_len; j++) begin
                up_old = match_row[j];
                if (pattern_mem[j] == STAR_BYTE)
                    entry = left_new | up_old;
                else if (pattern_mem[j] == ANY_BYTE || pattern_mem[j] == c)
                    entry = diag_old;
                else
                    entry = 1'b0;
                next_row[j] = entry;
                left_new = entry;
                diag_old = up_old;
            end
            match_row  = next_row;
            text_empty = 1'b0;
        endfunction

        // Accepted input transaction: update state, queue the verdict
        function void note_input(t_cmd cmd, logic [SYM_W-1:0] sym);
            t_verdict v;
            logic     all_star;
            v.overflow = 1'b0;
            case (cmd)
                CMD_CLEAR: begin
                    pattern_len = 0;
                    star_row    = '0;
                    restart_text();
                end
                CMD_APPEND: begin
                    if (pattern_len < PATTERN_DEPTH) begin
                        all_star = (pattern_len == 0) || star_row[pattern_len-1];
                        pattern_mem[pattern_len] = sym;
                        if (all_star && sym == STAR_BYTE)
                            star_row[pattern_len] = 1'b1;
                        pattern_len++;
                    end else begin
                        v.overflow = 1'b1;
                    end
                    restart_text();
                end
                CMD_START: restart_text();
                default:   consume_byte(sym);
            endcase
            v.matched = (pattern_len == 0) ? text_empty : match_row[pattern_len-1];
            owed_verdicts.push_back(v);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        task check_result(logic matched, logic overflow);
            t_verdict v;
            if (owed_verdicts.size() == 0) begin
                report_mismatch("result with no pending transaction");
            end else begin
                v = owed_verdicts.pop_front();
                if (matched !== v.matched)
                    report_mismatch($sformatf("matched got %b want %b", matched, v.matched));
                if (overflow !== v.overflow)
                    report_mismatch($sformatf("pattern_overflow got %b want %b",
                                              overflow, v.overflow));
            end
        endtask

        function int pending();
            return owed_verdicts.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;

    wpm_in_if  in_bus ();
    wpm_out_if out_bus ();

    wildcard_pattern_matcher DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    match_scoreboard board = new();

    // Stimulus-side copy of the pattern, used to build texts that match
    logic [SYM_W-1:0] gen_pattern [$];
    logic [SYM_W-1:0] text_bytes  [$];
    int               items_sent;
    bit               sender_calm;
    bit               receiver_calm;
    int               results_taken;

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Drive one input transaction, with a random lead-in gap
    task send_item(t_cmd cmd, logic [SYM_W-1:0] sym);
        int gap;
        if ($urandom_range(0, 29) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.command <= cmd;
        in_bus.symbol  <= sym;
        do @(posedge i_clk); while (!in_bus.ready);
        board.note_input(cmd, sym);
        items_sent++;
    endtask

    function automatic logic [SYM_W-1:0] pick_pattern_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 2) return STAR_BYTE;
        if (r <= 4) return ANY_BYTE;
        if (r <= 8) return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [SYM_W-1:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 6) return 8'h61 + 8'($urandom_range(0, 2));
        if (r == 7) return STAR_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Clear, then append n bytes; anything past the depth should overflow
    task load_pattern(int n);
        logic [SYM_W-1:0] b;
        gen_pattern.delete();
        send_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
        for (int i = 0; i < n; i++) begin
            b = pick_pattern_byte();
            if (gen_pattern.size() < PATTERN_DEPTH)
                gen_pattern.push_back(b);
            send_item(CMD_APPEND, b);
        end
    endtask

    // Build a text that matches the pattern, sometimes broken a little
    task stream_text();
        int pos;
        text_bytes.delete();
        foreach (gen_pattern[i]) begin
            if (gen_pattern[i] == STAR_BYTE) begin
                repeat ($urandom_range(0, 3)) text_bytes.push_back(pick_text_byte());
            end else if (gen_pattern[i] == ANY_BYTE) begin
                text_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                text_bytes.push_back(gen_pattern[i]);
            end
        end
        case ($urandom_range(0, 5))
            0: if (text_bytes.size() > 0) begin
                pos = $urandom_range(0, text_bytes.size() - 1);
                text_bytes[pos] = pick_text_byte();
            end
            1: if (text_bytes.size() > 0) void'(text_bytes.pop_back());
            2: text_bytes.push_back(pick_text_byte());
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0)
            send_item(CMD_START, 8'($urandom_range(0, 255)));
        foreach (text_bytes[i]) send_item(CMD_TEXT, text_bytes[i]);
    endtask

    task directed_items();
        // empty pattern: only the empty text matches
        send_item(CMD_TEXT, 8'h00);
        send_item(CMD_START, 8'hFF);
        // lone star matches anything, even a '*' text byte
        send_item(CMD_APPEND, STAR_BYTE);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_TEXT, STAR_BYTE);
        // "a?*" against "ax*", then growing the pattern restarts the text
        send_item(CMD_CLEAR, 8'h00);
        send_item(CMD_APPEND, 8'h61);
        send_item(CMD_APPEND, ANY_BYTE);
        send_item(CMD_APPEND, STAR_BYTE);
        send_item(CMD_TEXT, 8'h61);
        send_item(CMD_TEXT, 8'h78);
        send_item(CMD_TEXT, STAR_BYTE);
        send_item(CMD_START, 8'h00);
        send_item(CMD_APPEND, STAR_BYTE);
        send_item(CMD_TEXT, 8'h61);
        send_item(CMD_TEXT, 8'h00);
        // a '*' text byte is not a wildcard against a literal
        send_item(CMD_CLEAR, 8'hFF);
        send_item(CMD_APPEND, 8'h62);
        send_item(CMD_TEXT, STAR_BYTE);
        send_item(CMD_START, 8'h00);
        send_item(CMD_TEXT, 8'h62);
        send_item(CMD_TEXT, 8'hFF);
        send_item(CMD_CLEAR, 8'h00);
    endtask

    // Result receiver with random back-pressure
    initial begin
        int stall;
        out_bus.ready = 1'b0;
        receiver_calm = 1'b0;
        results_taken = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0)
                receiver_calm = !receiver_calm;
            stall = receiver_calm ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!out_bus.valid);
            board.check_result(out_bus.matched, out_bus.pattern_overflow);
            results_taken++;
        end
    end

    // Main stimulus
    initial begin
        int n;
        int r;
        in_bus.valid   = 1'b0;
        in_bus.command = CMD_CLEAR;
        in_bus.symbol  = '0;
        i_rst_n        = 1'b0;
        items_sent     = 0;
        sender_calm    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();

        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
                // well-formed: fresh pattern, then several texts against it
                case ($urandom_range(0, 11))
                    0:       n = $urandom_range(9, PATTERN_DEPTH - 1);
                    1:       n = PATTERN_DEPTH + $urandom_range(0, 3);
                    default: n = $urandom_range(0, 8);
                endcase
                load_pattern(n);
                repeat ($urandom_range(1, 4)) stream_text();
            end else begin
                // noise: arbitrary commands and bytes
                repeat ($urandom_range(1, 12))
                    send_item(t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end

        in_bus.valid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
